// ===== rtl/core/fgde_pkg.sv =====
// Shared types and constants of the four-gram dictionary encoder.
package fgde_pkg;

    localparam int CHAR_W           = 7;
    localparam int SYM_W            = 8;
    localparam int IDX_W            = 7;
    localparam int GRAM_W           = 32;
    localparam int CFG_W            = 8;
    localparam int CNT_W            = 2;
    localparam int WIN_DEPTH        = 4;
    localparam int DICT_ENTRIES_DEF = 128;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    // top bit of a code symbol
    localparam logic SYM_CODE = 1'b1;
    localparam logic SYM_RAW  = 1'b0;

    typedef struct packed {
        logic              req_type;
        logic [IDX_W-1:0]  entry_index;
        logic [GRAM_W-1:0] entry_gram;
        logic [CHAR_W-1:0] data_byte;
        logic              last_byte;
    } fgde_in_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last_symbol;
    } fgde_out_t;

    // dictionary write bus, seen by every cell
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [GRAM_W-1:0] gram;
    } fgde_wr_t;

    // search token moving down the chain
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [GRAM_W-1:0] key;
    } fgde_token_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_EMIT
    } fgde_state_t;

endpackage

// ===== rtl/core/fgde_cell.sv =====
// One dictionary cell: holds a gram, checks the passing token, hands it on.
module fgde_cell
    import fgde_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  fgde_wr_t          wr,
    input  logic [CFG_W-1:0]  entries_in_use,
    input  fgde_token_t       tok_in,
    output fgde_token_t       tok_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CFG_W-1:0] MY_NUM = CFG_W'(CELL_IDX);

    logic [GRAM_W-1:0] gram_reg;
    logic              valid_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [GRAM_W-1:0] key_reg;

    logic              enabled;
    logic              match;

    assign enabled = (MY_NUM < entries_in_use);
    assign match   = enabled && (gram_reg == tok_in.key);

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.idx == MY_IDX))
        begin
            gram_reg <= wr.gram;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    // lowest index wins: an earlier hit is never replaced
    always_ff @(posedge clk)
    begin
        key_reg <= tok_in.key;
        hit_reg <= tok_in.hit || match;
        idx_reg <= tok_in.hit ? tok_in.idx : MY_IDX;
    end

    assign tok_out = '{valid: valid_reg, hit: hit_reg, idx: idx_reg, key: key_reg};

endmodule

// ===== rtl/core/fgde_ctrl.sv =====
// Window, flush sequencing and output register of the encoder.
module fgde_ctrl
    import fgde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  fgde_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output fgde_out_t   out_data,
    output fgde_wr_t    wr,
    output fgde_token_t launch,
    input  fgde_token_t done
);

    fgde_state_t       state_reg, state_next;
    logic [CHAR_W-1:0] win_reg  [WIN_DEPTH];
    logic [CHAR_W-1:0] win_next [WIN_DEPTH];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  nm1_reg, nm1_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              last_reg, last_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  code_reg, code_next;
    logic              out_valid_reg, out_valid_next;
    fgde_out_t         out_reg, out_next;

    logic in_fire;
    logic is_data;
    logic full;
    logic out_free;
    logic push;

    assign in_fire  = in_valid && in_ready;
    assign is_data  = (in_data.req_type == REQ_DATA);
    assign full     = (cnt_reg == CNT_W'(WIN_DEPTH - 1));
    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && is_data)
                begin
                    if (full)
                        state_next = ST_SEARCH;
                    else if (in_data.last_byte)
                        state_next = ST_EMIT;
                end
            end
            ST_SEARCH:
            begin
                if (done.valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!hit_reg && last_reg)
                    state_next = ST_EMIT;
                else if (out_free)
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free && (pos_reg == nm1_reg))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        out_next = out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SEARCH:
            begin
                push = 1'b0;
            end
            ST_DECIDE:
            begin
                if (hit_reg)
                begin
                    push     = out_free;
                    out_next = '{symbol: {SYM_CODE, code_reg}, last_symbol: last_reg};
                end
                else if (!last_reg)
                begin
                    push     = out_free;
                    out_next = '{symbol: {SYM_RAW, win_reg[0]}, last_symbol: 1'b0};
                end
            end
            ST_EMIT:
            begin
                push     = out_free;
                out_next = '{symbol: {SYM_RAW, win_reg[pos_reg]},
                             last_symbol: (pos_reg == nm1_reg)};
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign wr = '{en: in_fire && !is_data, idx: in_data.entry_index,
                  gram: in_data.entry_gram};

    assign launch = '{valid: in_fire && is_data && full, hit: 1'b0, idx: '0,
                      key: {SYM_RAW, in_data.data_byte, SYM_RAW, win_reg[2],
                            SYM_RAW, win_reg[1], SYM_RAW, win_reg[0]}};

    // window and bookkeeping
    always_comb
    begin
        win_next       = win_reg;
        cnt_next       = cnt_reg;
        nm1_next       = nm1_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        hit_next       = hit_reg;
        code_next      = code_reg;
        out_valid_next = push ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

        if (in_fire && is_data)
        begin
            win_next[cnt_reg] = in_data.data_byte;
            last_next         = in_data.last_byte;
            nm1_next          = cnt_reg;
            pos_next          = '0;
            if (full || in_data.last_byte)
                cnt_next = '0;
            else
                cnt_next = cnt_reg + CNT_W'(1);
        end

        if (state_reg == ST_SEARCH && done.valid)
        begin
            hit_next  = done.hit;
            code_next = done.idx;
        end

        // a miss mid-stream slides the window by one
        if (state_reg == ST_DECIDE && push && !hit_reg)
        begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = win_reg[3];
            cnt_next    = CNT_W'(WIN_DEPTH - 1);
        end

        if (state_reg == ST_EMIT && push)
            pos_next = pos_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        nm1_reg  <= nm1_next;
        pos_reg  <= pos_next;
        last_reg <= last_next;
        hit_reg  <= hit_next;
        code_reg <= code_next;
        if (push)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        done.valid |-> (state_reg == ST_SEARCH))
        else $error("search token left the chain outside a search");

    a_last_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_data && in_data.last_byte) |=> (state_reg != ST_IDLE))
        else $error("final byte did not start a flush");

    a_emit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pos_reg <= nm1_reg))
        else $error("flush position ran past the window");

    a_no_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        launch.valid |=> !in_ready)
        else $error("input taken while a search is in flight");
`endif

endmodule

// ===== rtl/core/four_gram_dictionary_encoder.sv =====
// Top level: configuration register, chain of dictionary cells and controller.
// Load items and bytes that only fill the window are taken back to back, one per cycle.
// A byte that completes a four-byte window sends a search token through the DICT_ENTRIES
// cells, one cell per cycle; the next item is taken once the resulting symbol is
// registered for output, and a miss on the final byte flushes all four bytes as raw
// symbols. A short final window of n bytes is flushed as n raw symbols.
// Async low reset clears state, window fill count, output valid and entries_in_use; window bytes and grams stay unset.
module four_gram_dictionary_encoder
    import fgde_pkg::*;
#(
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fgde_in_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output fgde_out_t        out_data,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    // number of grams searched; cells at or above it never hit
    logic [CFG_W-1:0] entries_reg;

    fgde_wr_t    wr;
    fgde_token_t tok [DICT_ENTRIES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            entries_reg <= cfg_wr_data;
        end
    end

    // window handling, flush and the output register
    fgde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .wr        (wr),
        .launch    (tok[0]),
        .done      (tok[DICT_ENTRIES])
    );

    // the dictionary: cell i holds gram i; the token visits cell 0 first, so
    // the first hit it picks up is the lowest-numbered match
    for (genvar i = 0; i < DICT_ENTRIES; i++)
    begin : g_cell
        fgde_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .wr             (wr),
            .entries_in_use (entries_reg),
            .tok_in         (tok[i]),
            .tok_out        (tok[i+1])
        );
    end

endmodule
